>>> rtl/spsub_pkg.sv
// ----------------------------------------------------------------------------
// spsub_pkg
// shared constants and helpers for the spline subdivision unit
// ----------------------------------------------------------------------------
package spsub_pkg;

    localparam int CtrlW    = 16;
    localparam int AccW     = 32;
    localparam int QShift   = 12;
    localparam int TW       = 13;
    localparam int LaneCnt  = 9;
    localparam int InW      = 4 * CtrlW;
    localparam int OutW     = (LaneCnt + 1) * CtrlW;
    localparam int Stages   = 5;

    typedef logic [AccW-1:0]  acc_t;
    typedef logic [CtrlW-1:0] ctrl_t;
    typedef logic [TW-1:0]    tparam_t;

    // eight interior parameters, then the segment end
    localparam tparam_t LANE_T [LaneCnt] = '{
        13'h01c7, 13'h038e, 13'h0555, 13'h071c, 13'h08e3,
        13'h0aaa, 13'h0c71, 13'h0e38, 13'h1000
    };

    function automatic acc_t sext_ctrl(input ctrl_t v);
        return {{(AccW-CtrlW){v[CtrlW-1]}}, v};
    endfunction

    // p moved a quarter of the way toward mid, low bits kept
    function automatic ctrl_t pull_q(input acc_t p, input acc_t mid);
        acc_t diff;
        acc_t adj;
        acc_t quarter;
        diff    = p - mid;
        adj     = diff[AccW-1] ? diff + acc_t'(3) : diff;
        quarter = acc_t'($signed(adj) >>> 2);
        return ctrl_t'(p - quarter);
    endfunction

endpackage

>>> rtl/spline_subdivision_q12_unit.sv
// ----------------------------------------------------------------------------
// spline_subdivision_q12_unit
// catmull-rom style subdivision of one coordinate into ten q12 samples
// ----------------------------------------------------------------------------
// Takes one item of four control values per cycle unless stalled and returns
// one item of ten values from the output register. The datapath is a five stage
// pipeline: a coefficient stage, then nine parallel lanes (one per parameter)
// of three multiply-add cells, each handing its accumulator to the next cell,
// then a pull cell that also serves as the output register. Each stage
// advances whenever the stage after it is empty or moving, so bubbles close
// up while a result waits for m_tready and the sustained rate is one item per
// cycle while m_tready stays high, set by one 32x13 multiply per cell.
// ----------------------------------------------------------------------------
module spline_subdivision_q12_unit
    import spsub_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [InW-1:0]  s_tdata,  // ctrl_a, ctrl_b, ctrl_c, ctrl_d
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [OutW-1:0] m_tdata   // smoothed_start, sample_one..eight, segment_end
);

    logic [Stages-1:0] vld_reg;
    logic [Stages-1:0] vld_next;
    logic [Stages-1:0] rdy;

    ctrl_t ctrl_a;
    ctrl_t ctrl_b;
    ctrl_t ctrl_c;
    ctrl_t ctrl_d;
    acc_t  a32;
    acc_t  b32;
    acc_t  c32;
    acc_t  d32;
    acc_t  sum_bc;
    acc_t  mid32;

    acc_t  c3_reg;
    acc_t  c3_next;
    acc_t  c2_reg;
    acc_t  c2_next;
    acc_t  c1_s1_reg;
    acc_t  c1_next;
    ctrl_t b_s1_reg;
    ctrl_t mid_s1_reg;
    ctrl_t mid_next;
    ctrl_t sm_s1_reg;
    ctrl_t sm_next;

    acc_t  c1_s2_reg;
    ctrl_t b_s2_reg;
    ctrl_t mid_s2_reg;
    ctrl_t sm_s2_reg;
    ctrl_t b_s3_reg;
    ctrl_t mid_s3_reg;
    ctrl_t sm_s3_reg;
    ctrl_t mid_s4_reg;
    ctrl_t sm_s4_reg;
    ctrl_t sm_s5_reg;

    acc_t  acc1 [LaneCnt];
    acc_t  acc2 [LaneCnt];
    acc_t  acc3 [LaneCnt];
    ctrl_t res  [LaneCnt];

    // ready chain, last stage first
    always_comb
    begin
        rdy[Stages-1] = !vld_reg[Stages-1] || m_tready;
        for (int i = Stages - 2; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (rdy[0])
        begin
            vld_next[0] = s_tvalid;
        end
        for (int i = 1; i < Stages; i++)
        begin
            if (rdy[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[Stages-1];

    // coefficient stage
    always_comb
    begin
        ctrl_a  = s_tdata[0*CtrlW +: CtrlW];
        ctrl_b  = s_tdata[1*CtrlW +: CtrlW];
        ctrl_c  = s_tdata[2*CtrlW +: CtrlW];
        ctrl_d  = s_tdata[3*CtrlW +: CtrlW];
        a32     = sext_ctrl(ctrl_a);
        b32     = sext_ctrl(ctrl_b);
        c32     = sext_ctrl(ctrl_c);
        d32     = sext_ctrl(ctrl_d);
        c3_next = acc_t'(3) * (b32 - c32) - a32 + d32;
        c2_next = ((a32 + (c32 << 1)) << 1) - acc_t'(5) * b32 - d32;
        c1_next = c32 - a32;
        sum_bc  = b32 + c32;
        mid32   = acc_t'($signed(sum_bc[AccW-1] ? sum_bc + acc_t'(1) : sum_bc) >>> 1);
        mid_next = ctrl_t'(mid32);
        sm_next  = pull_q(b32, mid32);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            c3_reg     <= c3_next;
            c2_reg     <= c2_next;
            c1_s1_reg  <= c1_next;
            b_s1_reg   <= ctrl_b;
            mid_s1_reg <= mid_next;
            sm_s1_reg  <= sm_next;
        end
        if (rdy[1])
        begin
            c1_s2_reg  <= c1_s1_reg;
            b_s2_reg   <= b_s1_reg;
            mid_s2_reg <= mid_s1_reg;
            sm_s2_reg  <= sm_s1_reg;
        end
        if (rdy[2])
        begin
            b_s3_reg   <= b_s2_reg;
            mid_s3_reg <= mid_s2_reg;
            sm_s3_reg  <= sm_s2_reg;
        end
        if (rdy[3])
        begin
            mid_s4_reg <= mid_s3_reg;
            sm_s4_reg  <= sm_s3_reg;
        end
        if (rdy[4])
        begin
            sm_s5_reg  <= sm_s4_reg;
        end
    end

    // one lane per parameter
    for (genvar ln = 0; ln < LaneCnt; ln++)
    begin : g_lane
        spsub_horner_cell u_h1
        (
            .clk     (clk),
            .en      (rdy[1]),
            .t       (LANE_T[ln]),
            .acc_in  (c3_reg),
            .coef    (c2_reg),
            .acc_out (acc1[ln])
        );

        spsub_horner_cell u_h2
        (
            .clk     (clk),
            .en      (rdy[2]),
            .t       (LANE_T[ln]),
            .acc_in  (acc1[ln]),
            .coef    (c1_s2_reg),
            .acc_out (acc2[ln])
        );

        spsub_horner_cell u_h3
        (
            .clk     (clk),
            .en      (rdy[3]),
            .t       (LANE_T[ln]),
            .acc_in  (acc2[ln]),
            .coef    (sext_ctrl(b_s3_reg)),
            .acc_out (acc3[ln])
        );

        spsub_pull_cell u_pull
        (
            .clk (clk),
            .en  (rdy[4]),
            .p   (acc3[ln]),
            .mid (mid_s4_reg),
            .res (res[ln])
        );

        assign m_tdata[(ln+1)*CtrlW +: CtrlW] = res[ln];
    end

    assign m_tdata[0 +: CtrlW] = sm_s5_reg;

endmodule

>>> rtl/spsub_horner_cell.sv
// ----------------------------------------------------------------------------
// spsub_horner_cell
// one horner step: acc * t in q12, plus the next coefficient, registered
// ----------------------------------------------------------------------------
module spsub_horner_cell
    import spsub_pkg::*;
(
    input  logic    clk,
    input  logic    en,
    input  tparam_t t,
    input  acc_t    acc_in,
    input  acc_t    coef,
    output acc_t    acc_out
);

    acc_t prod;
    acc_t acc_reg;
    acc_t acc_next;

    always_comb
    begin
        prod     = acc_in * acc_t'(t);
        acc_next = acc_t'($signed(prod) >>> QShift) + coef;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc_out = acc_reg;

endmodule

>>> rtl/spsub_pull_cell.sv
// ----------------------------------------------------------------------------
// spsub_pull_cell
// final step of a lane: pull toward the segment midpoint, registered
// ----------------------------------------------------------------------------
module spsub_pull_cell
    import spsub_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  acc_t  p,
    input  ctrl_t mid,
    output ctrl_t res
);

    ctrl_t res_reg;
    ctrl_t res_next;

    always_comb
    begin
        res_next = pull_q(p, sext_ctrl(mid));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

>>> rtl/spsub_checker.sv
// ----------------------------------------------------------------------------
// spsub_checker
// port-level checks for the spline subdivision unit
// ----------------------------------------------------------------------------
module spsub_checker
    import spsub_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            s_tvalid,
    input logic            s_tready,
    input logic            m_tvalid,
    input logic            m_tready,
    input logic [OutW-1:0] m_tdata
);

    // result held until taken
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed while stalled");

    // free-running output means the whole pipe moves
    a_ready_pass: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled with output ready");

    // fixed latency when nothing stalls
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $past(s_tvalid && s_tready, 5) && $past(rst_n, 5)
        && $past(rst_n, 4) && $past(rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1)
        && $past(m_tready, 4) && $past(m_tready, 3)
        && $past(m_tready, 2) && $past(m_tready, 1)
        |-> m_tvalid)
        else $error("result missing after five cycles");

endmodule

bind spline_subdivision_q12_unit spsub_checker u_spsub_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> test/tb_spline_subdivision_q12_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_spline_subdivision_q12_unit
// self-checking bench for the spline subdivision unit
// ----------------------------------------------------------------------------
// Streams windows of four control values into the unit and predicts the ten
// subdivided values of every accepted window with a 32-bit wrapping model of
// the cubic and the quarter pull toward the segment midpoint. A directed set
// covers field extremes, odd and negative midpoints and intermediate wrap;
// random windows follow, mixing full-range, extreme, small and smooth values.
// Both sides idle at random in runs, some of them with no gaps at all.
// ----------------------------------------------------------------------------
module tb_spline_subdivision_q12_unit;
    import spsub_pkg::*;

    localparam int SampleCnt   = LaneCnt + 1;
    localparam int RandomItems = 1280;
    localparam int DrainCycles = 20;

    localparam logic [AccW-1:0] SAMPLE_T [LaneCnt] = '{
        32'h01c7, 32'h038e, 32'h0555, 32'h071c, 32'h08e3,
        32'h0aaa, 32'h0c71, 32'h0e38, 32'h1000
    };

    localparam ctrl_t CTRL_MAX = 16'h7fff;
    localparam ctrl_t CTRL_MIN = 16'h8000;

    // ctrl_a in the lowest bits
    typedef struct packed {
        ctrl_t d;
        ctrl_t c;
        ctrl_t b;
        ctrl_t a;
    } ctrl_window_t;

    // index 0 is smoothed_start, index SampleCnt-1 is segment_end
    typedef ctrl_t [SampleCnt-1:0] sample_set_t;

    logic            clk      = 1'b0;
    logic            rst_n    = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [InW-1:0]  s_tdata  = '0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [OutW-1:0] m_tdata;

    ctrl_window_t pending_windows[$];
    sample_set_t  expected_samples[$];

    int total_windows = 0;
    int accepted_cnt  = 0;
    int fail_cnt      = 0;
    int send_gap      = 0;
    int ready_stall   = 0;
    int drv_run       = 0;
    int mon_run       = 0;
    bit drv_calm      = 1'b0;
    bit mon_calm      = 1'b0;

    string sample_names [SampleCnt] = '{
        "smoothed_start", "sample_one", "sample_two", "sample_three", "sample_four",
        "sample_five", "sample_six", "sample_seven", "sample_eight", "segment_end"
    };

    spline_subdivision_q12_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // signed division by 2^k rounding toward zero
    function automatic logic [AccW-1:0] trunc_div_pow2(input logic [AccW-1:0] x, input int k);
        logic [AccW-1:0] v;
        v = x;
        if (v[AccW-1])
            v = v + ((32'd1 << k) - 32'd1);
        return $signed(v) >>> k;
    endfunction

    function automatic ctrl_t pull_toward_mid(input logic [AccW-1:0] p, input logic [AccW-1:0] mid);
        logic [AccW-1:0] r;
        r = p - trunc_div_pow2(p - mid, 2);
        return r[CtrlW-1:0];
    endfunction

    function automatic sample_set_t subdivide_window(input ctrl_window_t w);
        logic [AccW-1:0] a, b, c, d, mid, q, p, t;
        sample_set_t     s;
        a   = {{(AccW-CtrlW){w.a[CtrlW-1]}}, w.a};
        b   = {{(AccW-CtrlW){w.b[CtrlW-1]}}, w.b};
        c   = {{(AccW-CtrlW){w.c[CtrlW-1]}}, w.c};
        d   = {{(AccW-CtrlW){w.d[CtrlW-1]}}, w.d};
        mid = trunc_div_pow2(b + c, 1);
        s[0] = pull_toward_mid(b, mid);
        for (int k = 0; k < LaneCnt; k++)
        begin
            t = SAMPLE_T[k];
            q = (b - c) * 32'd3 - a + d;
            q = $signed(q * t) >>> QShift;
            p = (a + c * 32'd2) * 32'd2 + q - b * 32'd5 - d;
            p = $signed(p * t) >>> QShift;
            p = p - a + c;
            p = $signed(p * t) >>> QShift;
            p = p + b;
            s[k + 1] = pull_toward_mid(p, mid);
        end
        return s;
    endfunction

    // runs of gap-free traffic mix at random with runs of random waits
    function automatic int draw_wait(inout int run_left, inout bit calm);
        if (run_left == 0)
        begin
            run_left = $urandom_range(8, 80);
            calm     = ($urandom_range(0, 3) == 0);
        end
        run_left--;
        return calm ? 0 : int'($urandom_range(0, 11));
    endfunction

    function automatic ctrl_t pick_extreme();
        case ($urandom_range(0, 4))
            0:       return CTRL_MAX;
            1:       return CTRL_MIN;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return 16'h0001;
        endcase
    endfunction

    task automatic add_window(input ctrl_t a, input ctrl_t b, input ctrl_t c, input ctrl_t d);
        ctrl_window_t w;
        w.a = a;
        w.b = b;
        w.c = c;
        w.d = d;
        pending_windows.push_back(w);
        total_windows++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (send_gap > 0)
            begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_windows.size() != 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_windows.pop_front();
                send_gap <= draw_wait(drv_run, drv_calm);
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        sample_set_t want;
        sample_set_t got;
        int          w;
        if (!rst_n)
        begin
            m_tready    <= 1'b0;
            ready_stall <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_samples.push_back(subdivide_window(s_tdata));
                accepted_cnt++;
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (expected_samples.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected item: %h", got);
                end
                else
                begin
                    want = expected_samples.pop_front();
                    for (int k = 0; k < SampleCnt; k++)
                    begin
                        if (got[k] !== want[k])
                        begin
                            fail_cnt++;
                            if (fail_cnt <= 10)
                                $display("%s mismatch: expected %0d, got %0d",
                                         sample_names[k], $signed(want[k]), $signed(got[k]));
                        end
                    end
                end
                w = draw_wait(mon_run, mon_calm);
                if (w == 0)
                begin
                    m_tready <= 1'b1;
                end
                else
                begin
                    m_tready    <= 1'b0;
                    ready_stall <= w - 1;
                end
            end
            else if (!m_tready)
            begin
                if (ready_stall == 0)
                    m_tready <= 1'b1;
                else
                    ready_stall <= ready_stall - 1;
            end
        end
    end

    initial
    begin
        logic [15:0] base;
        int          mode;

        // zero, full-scale and mixed-sign corners
        add_window(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        add_window(CTRL_MAX, CTRL_MAX, CTRL_MAX, CTRL_MAX);
        add_window(CTRL_MIN, CTRL_MIN, CTRL_MIN, CTRL_MIN);
        add_window(CTRL_MIN, CTRL_MAX, CTRL_MIN, CTRL_MAX);
        add_window(CTRL_MAX, CTRL_MIN, CTRL_MAX, CTRL_MIN);
        add_window(CTRL_MAX, CTRL_MIN, CTRL_MIN, CTRL_MAX);
        add_window(CTRL_MIN, CTRL_MAX, CTRL_MAX, CTRL_MIN);
        // intermediate wrap of the cubic terms
        add_window(CTRL_MAX, CTRL_MIN, CTRL_MAX, CTRL_MAX);
        add_window(CTRL_MIN, CTRL_MAX, CTRL_MIN, CTRL_MIN);
        add_window(CTRL_MIN, CTRL_MIN, CTRL_MAX, CTRL_MIN);
        add_window(CTRL_MAX, CTRL_MAX, CTRL_MIN, CTRL_MAX);
        // odd and negative midpoints, truncation toward zero
        add_window(16'h0000, 16'hffff, 16'h0000, 16'h0000);
        add_window(16'h0000, 16'h0000, 16'hffff, 16'h0000);
        add_window(16'h0000, 16'hfffd, 16'h0000, 16'h0000);
        add_window(16'h0000, 16'h0003, 16'h0000, 16'h0000);
        add_window(16'h0000, 16'hfff9, 16'h0002, 16'h0000);
        add_window(16'h0005, 16'h0007, 16'hfffa, 16'hfffb);
        // straight line and flat segment
        add_window(16'h0000, 16'h0100, 16'h0200, 16'h0300);
        add_window(16'h1234, 16'h1234, 16'h1234, 16'h1234);
        add_window(16'hff00, 16'h0100, 16'h0100, 16'hff00);
        // single outer point, then alternating values
        add_window(CTRL_MAX, 16'h0000, 16'h0000, 16'h0000);
        add_window(16'h0000, 16'h0000, 16'h0000, CTRL_MIN);
        add_window(16'haaaa, 16'h5555, 16'haaaa, 16'h5555);

        for (int i = 0; i < RandomItems; i++)
        begin
            mode = $urandom_range(0, 9);
            if (mode < 4)
            begin
                add_window(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            end
            else if (mode < 6)
            begin
                add_window(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
            end
            else if (mode < 8)
            begin
                add_window(16'($signed($urandom_range(0, 127)) - 64),
                           16'($signed($urandom_range(0, 127)) - 64),
                           16'($signed($urandom_range(0, 127)) - 64),
                           16'($signed($urandom_range(0, 127)) - 64));
            end
            else
            begin
                base = 16'($urandom);
                add_window(base + 16'($urandom_range(0, 1023)) - 16'd512,
                           base + 16'($urandom_range(0, 1023)) - 16'd512,
                           base + 16'($urandom_range(0, 1023)) - 16'd512,
                           base + 16'($urandom_range(0, 1023)) - 16'd512);
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_cnt < total_windows || expected_samples.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (fail_cnt == 0 && expected_samples.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/spsub_pkg.sv
rtl/spsub_horner_cell.sv
rtl/spsub_pull_cell.sv
rtl/spline_subdivision_q12_unit.sv
rtl/spsub_checker.sv
test/tb_spline_subdivision_q12_unit.sv
